FILE: rtl/core/frnn_pkg.sv
// Shared types, constants and state encoding for the fixed-radius neighbor search core.
package frnn_pkg;

   // Field widths fixed by the request and response formats.
   localparam int COORD_W     = 16;
   localparam int INDEX_W     = 8;
   localparam int RADIUS_W    = 35;
   localparam int COUNT_W     = 9;
   localparam int MASK_W      = 64;
   localparam int WORD_W      = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = RADIUS_W;

   // Index space reachable by point_index, and the mask words that cover it.
   localparam int INDEX_LIMIT = 256;
   localparam int NUM_WORDS   = INDEX_LIMIT / MASK_W;

   // Default configuration of the core.
   localparam int DEF_MAX_POINTS = 256;
   localparam int DEF_DIMS       = 2;
   localparam int DEF_COORD_BITS = 16;

   // Register reset values.
   localparam logic [COUNT_W-1:0]  POINT_COUNT_RESET = COUNT_W'(256);
   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET   = '0;

   // Request commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS_SQ   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_COUNT = 1'b1;

   // Request payload.
   typedef struct packed {
      logic                      command;
      logic [INDEX_W-1:0]        point_index;
      logic signed [COORD_W-1:0] coord_0;
      logic signed [COORD_W-1:0] coord_1;
      logic signed [COORD_W-1:0] coord_2;
      logic signed [COORD_W-1:0] coord_3;
   } frnn_req_type;

   // Response payload.
   typedef struct packed {
      logic [WORD_W-1:0] word_index;
      logic [MASK_W-1:0] neighbor_mask;
      logic              last_word;
   } frnn_rsp_type;

   // Control that travels with one point into the distance pipeline.
   typedef struct packed {
      logic               valid;
      logic               skip;
      logic [INDEX_W-1:0] tag;
   } frnn_job_type;

   // Verdict for one point leaving the distance pipeline.
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [INDEX_W-1:0] tag;
   } frnn_hit_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_QUERY,
      S_SCAN,
      S_DRAIN,
      S_EMIT
   } frnn_state_type;

endpackage

FILE: rtl/core/frnn_dist.sv
// Pipelined squared-distance unit: one point pair per cycle, verdict from the registered compare stage.
module frnn_dist #(
   parameter int DIMS       = frnn_pkg::DEF_DIMS,
   parameter int COORD_BITS = frnn_pkg::DEF_COORD_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  frnn_pkg::frnn_job_type           job,
   input  logic [DIMS*COORD_BITS-1:0]       point_a,
   input  logic [DIMS*COORD_BITS-1:0]       point_b,
   input  logic [frnn_pkg::RADIUS_W-1:0]    radius_sq,
   output frnn_pkg::frnn_hit_type           result,
   output logic                             busy
);
   import frnn_pkg::*;

   localparam int SQ_W  = 2 * COORD_BITS;
   localparam int SUM_W = SQ_W + 2;
   localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;

   frnn_job_type                    s1_ff, s2_ff, s3_ff;
   logic [DIMS-1:0][COORD_BITS-1:0] abs_in, abs_ff;
   logic [DIMS-1:0][SQ_W-1:0]       sq_in, sq_ff;
   logic [SUM_W-1:0]                sum_in, sum_ff;
   frnn_hit_type                    result_in, result_ff;

   // Stage 1: per-axis difference magnitude of the sign-extended coordinates.
   always_comb begin
      logic signed [COORD_BITS:0] ca;
      logic signed [COORD_BITS:0] cb;
      logic signed [COORD_BITS:0] diff;
      logic        [COORD_BITS:0] mag;
      for (int d = 0; d < DIMS; d++) begin
         ca   = {point_a[d*COORD_BITS + COORD_BITS-1], point_a[d*COORD_BITS +: COORD_BITS]};
         cb   = {point_b[d*COORD_BITS + COORD_BITS-1], point_b[d*COORD_BITS +: COORD_BITS]};
         diff = ca - cb;
         mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : diff;
         abs_in[d] = mag[COORD_BITS-1:0];
      end
   end

   // Stage 2: one multiplier per axis squares the magnitude.
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         sq_in[d] = SQ_W'(abs_ff[d]) * SQ_W'(abs_ff[d]);
      end
   end

   // Stage 3: sum of the squares.
   always_comb begin
      sum_in = '0;
      for (int d = 0; d < DIMS; d++) begin
         sum_in = sum_in + SUM_W'(sq_ff[d]);
      end
   end

   // Stage 4: compare against the radius, never marking the queried point.
   always_comb begin
      result_in.valid = s3_ff.valid;
      result_in.tag   = s3_ff.tag;
      result_in.hit   = !s3_ff.skip && (CMP_W'(sum_ff) <= CMP_W'(radius_sq));
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s2_ff     <= '0;
         s3_ff     <= '0;
         result_ff <= '0;
      end else begin
         s1_ff     <= job;
         s2_ff     <= s1_ff;
         s3_ff     <= s2_ff;
         result_ff <= result_in;
      end
   end

   // Pipeline data.
   always_ff @(posedge clock) begin
      abs_ff <= abs_in;
      sq_ff  <= sq_in;
      sum_ff <= sum_in;
   end

   assign result = result_ff;
   assign busy   = s1_ff.valid | s2_ff.valid | s3_ff.valid | result_ff.valid;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> ##4 result.valid)
      else $error("distance verdict missing four cycles after a job");
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      !job.valid |-> ##4 !result.valid)
      else $error("distance verdict without a job");
   a_skip_clear: assert property (@(posedge clock) disable iff (reset)
      (job.valid && job.skip) |-> ##4 !result.hit)
      else $error("queried point marked as its own neighbor");
`endif

endmodule

FILE: rtl/core/fixed_radius_neighbor_search_core.sv
// Top level of the fixed-radius neighbor search core: point store, sequencer and mask buffer.
//
// A load request writes one point into the point store. A query request reads the named
// point, then streams every point below the effective count (point_count capped at
// MAX_POINTS and at 256) out of the point store, one per cycle, through one four-stage
// squared-distance pipeline. A query passes through setup, scanning, draining and mask
// output, and returns one mask word (ceil(count/64), at least one) per cycle while
// rsp_ready stays high; mask output waits while rsp_ready is low. The core takes no request
// during a query. Store entries are undefined after reset, and a query must not touch a
// point that was never loaded. Configuration writes must come only while the core is idle.
module fixed_radius_neighbor_search_core #(
   parameter int MAX_POINTS = frnn_pkg::DEF_MAX_POINTS,
   parameter int DIMS       = frnn_pkg::DEF_DIMS,
   parameter int COORD_BITS = frnn_pkg::DEF_COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  frnn_pkg::frnn_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output frnn_pkg::frnn_rsp_type            rsp_payload,
   input  logic                              csr_we,
   input  logic [frnn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [frnn_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import frnn_pkg::*;

   localparam int SCAN_LIMIT = (MAX_POINTS < INDEX_LIMIT) ? MAX_POINTS : INDEX_LIMIT;
   localparam int MEM_AW     = $clog2(MAX_POINTS);
   localparam int PT_W       = DIMS * COORD_BITS;

   // Configuration registers.
   logic [RADIUS_W-1:0] radius_sq_ff;
   logic [COUNT_W-1:0]  point_count_ff;

   // Sequencer and query context.
   frnn_state_type      state_ff, state_in;
   logic [COUNT_W-1:0]  p_ff, p_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0]   last_ff, last_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [INDEX_W-1:0]  qidx_ff;
   logic [PT_W-1:0]     q_ff;

   // Point store and its read stage.
   logic [PT_W-1:0]     store_mem [MAX_POINTS];
   logic [MEM_AW-1:0]   rd_addr;
   logic [PT_W-1:0]     rd_data_ff;
   logic                rd_vld_ff;
   logic [INDEX_W-1:0]  rd_idx_ff;
   logic                issue;

   // Request decode.
   logic                req_fire;
   logic                idx_ok;
   logic                load_fire;
   logic                query_fire;
   logic [3:0][COORD_W-1:0] coord_arr;
   logic [PT_W-1:0]     load_word;

   // Distance pipeline and mask buffer.
   frnn_job_type        job;
   frnn_hit_type        hit;
   logic                dist_busy;
   logic [NUM_WORDS-1:0][MASK_W-1:0] mask_ff;

   // Request decode and point packing.
   assign req_fire   = req_valid && req_ready;
   assign idx_ok     = (32'(req_payload.point_index) < 32'(MAX_POINTS));
   assign load_fire  = req_fire && idx_ok && (req_payload.command == CMD_LOAD);
   assign query_fire = req_fire && idx_ok && (req_payload.command == CMD_QUERY);

   always_comb begin
      coord_arr[0] = req_payload.coord_0;
      coord_arr[1] = req_payload.coord_1;
      coord_arr[2] = req_payload.coord_2;
      coord_arr[3] = req_payload.coord_3;
      for (int d = 0; d < DIMS; d++) begin
         load_word[d*COORD_BITS +: COORD_BITS] = coord_arr[d][COORD_BITS-1:0];
      end
   end

   // Effective count and index of the last mask word, fixed at query start.
   always_comb begin
      logic [COUNT_W-1:0] cnt_m1;
      count_in = (point_count_ff > COUNT_W'(SCAN_LIMIT)) ? COUNT_W'(SCAN_LIMIT)
                                                          : point_count_ff;
      cnt_m1   = count_in - COUNT_W'(1);
      last_in  = (count_in == '0) ? '0 : cnt_m1[7:6];
   end

   // Sequencer next state and outputs.
   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      word_in   = word_ff;
      issue     = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rd_addr   = MEM_AW'(p_ff);
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = MEM_AW'(req_payload.point_index);
            if (query_fire) begin
               state_in = S_QUERY;
            end
         end
         S_QUERY: begin
            p_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (p_ff < count_ff) begin
               issue = 1'b1;
               p_in  = p_ff + COUNT_W'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_vld_ff && !dist_busy) begin
               word_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (word_ff == last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  word_in = word_ff + WORD_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rd_vld_ff      <= 1'b0;
         radius_sq_ff   <= RADIUS_SQ_RESET;
         point_count_ff <= POINT_COUNT_RESET;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS_SQ:   radius_sq_ff   <= csr_wdata[RADIUS_W-1:0];
               CSR_POINT_COUNT: point_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Query context and counters.
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      word_ff   <= word_in;
      rd_idx_ff <= p_ff[INDEX_W-1:0];
      if (query_fire) begin
         qidx_ff  <= req_payload.point_index;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
      if (state_ff == S_QUERY) begin
         q_ff <= rd_data_ff;
      end
   end

   // Point store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (load_fire) begin
         store_mem[MEM_AW'(req_payload.point_index)] <= load_word;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Feed the distance pipeline with the point just read.
   always_comb begin
      job.valid = rd_vld_ff;
      job.skip  = (rd_idx_ff == qidx_ff);
      job.tag   = rd_idx_ff;
   end

   frnn_dist #(
      .DIMS       (DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .point_a   (rd_data_ff),
      .point_b   (q_ff),
      .radius_sq (radius_sq_ff),
      .result    (hit),
      .busy      (dist_busy)
   );

   // Mask buffer: cleared at query start, one bit written per verdict.
   always_ff @(posedge clock) begin
      if (query_fire) begin
         mask_ff <= '0;
      end else if (hit.valid) begin
         mask_ff[hit.tag[7:6]][hit.tag[5:0]] <= hit.hit;
      end
   end

   // Response word.
   always_comb begin
      rsp_payload.word_index    = word_ff;
      rsp_payload.neighbor_mask = mask_ff[word_ff];
      rsp_payload.last_word     = (word_ff == last_ff);
   end

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!rd_vld_ff && !dist_busy))
      else $error("distance pipeline busy while the core is idle");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (p_ff <= count_ff))
      else $error("scan pointer ran past the effective count");
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> (COUNT_W'(hit.tag) < count_ff))
      else $error("verdict for a point outside the effective count");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_payload.last_word) |=> (state_ff == S_IDLE))
      else $error("core not idle after the last mask word");
`endif

endmodule

FILE: bench/tb_fixed_radius_neighbor_search_core.sv
// Self-checking testbench for the fixed-radius neighbor search core.
module tb_fixed_radius_neighbor_search_core;
   timeunit 1ns;
   timeprecision 1ps;

   import frnn_pkg::*;

   // Cycles allowed for the core to settle after the last expected mask word, before a register write or the end.
   localparam int SETTLE_CYCLES = 300;

   // Kinds of rows in the directed stimulus.
   typedef enum logic [1:0] {
      ROW_REG,
      ROW_LOAD,
      ROW_QUERY
   } row_kind_type;

   // One directed row: a register write, a point load or a query.
   // A query with fixed set carries its single mask word inline.
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_W-1:0]    reg_sel;
      logic [CSR_DATA_W-1:0]     value;
      logic [INDEX_W-1:0]        index;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic                      fixed;
      logic [MASK_W-1:0]         mask;
   } row_type;

   // One random phase: register settings, request count and whether idling is off.
   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [RADIUS_W-1:0] radius;
      logic [15:0]         items;
      logic                quiet;
   } phase_type;

   localparam int DIR_ROWS = 24;
   localparam row_type DIR_TABLE [DIR_ROWS] = '{
      '{ROW_REG,   CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_REG,   CSR_POINT_COUNT, 35'd4,           8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sh8000, 16'sh8000, 1'b0, 64'd0},
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd1,   16'sh7FFF, 16'sh7FFF, 1'b0, 64'd0},
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd2,   16'sh8000, 16'sh8000, 1'b0, 64'd0},
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd3,   16'sd0,    16'sd0,    1'b0, 64'd0},
      // Zero radius still marks a coincident point.
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sd0,    16'sd0,    1'b1, 64'h4},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd3,   16'sd0,    16'sd0,    1'b1, 64'h0},
      '{ROW_REG,   CSR_RADIUS_SQ,   35'h7_FFFF_FFFF, 8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd1,   16'sd0,    16'sd0,    1'b1, 64'hD},
      // A queried point above the count is still compared with every point below the count.
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd200, 16'sd100,  -16'sd100, 1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd200, 16'sd0,    16'sd0,    1'b1, 64'hF},
      // Radius exactly at the largest distance, then one below it.
      '{ROW_REG,   CSR_RADIUS_SQ,   35'd8589672450,  8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sd0,    16'sd0,    1'b1, 64'hE},
      '{ROW_REG,   CSR_RADIUS_SQ,   35'd8589672449,  8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sd0,    16'sd0,    1'b1, 64'hC},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd3,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_LOAD,  CSR_RADIUS_SQ,   35'd0,           8'd3,   -16'sd32767, 16'sh7FFF, 1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd2,   16'sd0,    16'sd0,    1'b0, 64'd0},
      // Zero count answers with one empty final word.
      '{ROW_REG,   CSR_POINT_COUNT, 35'd0,           8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd1,   16'sd0,    16'sd0,    1'b1, 64'h0},
      '{ROW_REG,   CSR_POINT_COUNT, 35'd1,           8'd0,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd1,   16'sd0,    16'sd0,    1'b0, 64'd0},
      '{ROW_QUERY, CSR_RADIUS_SQ,   35'd0,           8'd0,   16'sd0,    16'sd0,    1'b1, 64'h0}
   };

   localparam int PHASES = 9;
   localparam phase_type PHASE_TABLE [PHASES] = '{
      '{9'd64,  35'd2000,        16'd80,  1'b0},
      '{9'd65,  35'd8000,        16'd25,  1'b0},
      '{9'd128, 35'd500,         16'd80,  1'b0},
      '{9'd256, 35'd20000,       16'd130, 1'b0},
      '{9'd511, 35'd0,           16'd10,  1'b0},
      '{9'd300, 35'h7_FFFF_FFFF, 16'd10,  1'b0},
      '{9'd1,   35'd5000,        16'd10,  1'b0},
      '{9'd200, 35'h4_0000_0000, 16'd10,  1'b0},
      '{9'd256, 35'd12000,       16'd20,  1'b1}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   frnn_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   frnn_rsp_type rsp_payload;
   logic         csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow of the point store and the registers, updated on acceptance.
   logic signed [COORD_W-1:0] pt_x [INDEX_LIMIT];
   logic signed [COORD_W-1:0] pt_y [INDEX_LIMIT];
   bit                        pt_written [INDEX_LIMIT];
   logic [RADIUS_W-1:0]       radius_q;
   logic [COUNT_W-1:0]        count_q;

   frnn_rsp_type mask_words_q [$];
   bit           no_idle;
   int           mismatch_count;
   int           requests_sent;
   int           queries_sent;
   int           words_checked;
   int           settings_used;

   fixed_radius_neighbor_search_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Report the first few mismatches in full and count the rest.
   function automatic void note_mismatch(input string msg);
      if (mismatch_count < 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      mismatch_count++;
   endfunction

   // Expected mask words for a query of point idx under the current settings.
   task automatic push_neighbor_words(input logic [INDEX_W-1:0] idx);
      int           eff;
      int           nwords;
      int           p;
      longint       dx;
      longint       dy;
      frnn_rsp_type word;
      eff = (count_q > COUNT_W'(INDEX_LIMIT)) ? INDEX_LIMIT : int'(count_q);
      nwords = (eff + MASK_W - 1) / MASK_W;
      if (nwords == 0) begin
         nwords = 1;
      end
      for (int wi = 0; wi < nwords; wi++) begin
         word.word_index = WORD_W'(wi);
         word.neighbor_mask = '0;
         word.last_word = (wi == nwords - 1);
         for (int k = 0; k < MASK_W; k++) begin
            p = wi * MASK_W + k;
            if (p < eff && p != int'(idx)) begin
               dx = longint'(pt_x[p]) - longint'(pt_x[idx]);
               dy = longint'(pt_y[p]) - longint'(pt_y[idx]);
               if (dx * dx + dy * dy <= longint'(radius_q)) begin
                  word.neighbor_mask[k] = 1'b1;
               end
            end
         end
         mask_words_q.push_back(word);
      end
   endtask

   // Hold the request channel idle for the given number of cycles.
   task automatic idle_requests(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Present one request, wait for its handshake and update the shadow state.
   task automatic send_request(input frnn_req_type item, input bit fixed,
                               input logic [MASK_W-1:0] fixed_mask);
      frnn_rsp_type word;
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         idle_requests($urandom_range(1, 15));
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
      if (item.command == CMD_LOAD) begin
         pt_x[item.point_index] = item.coord_0;
         pt_y[item.point_index] = item.coord_1;
         pt_written[item.point_index] = 1'b1;
      end else begin
         queries_sent++;
         if (fixed) begin
            word.word_index = '0;
            word.neighbor_mask = fixed_mask;
            word.last_word = 1'b1;
            mask_words_q.push_back(word);
         end else begin
            push_neighbor_words(item.point_index);
         end
      end
   endtask

   // Write a register once every mask word is back and the core has settled.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] sel,
                                 input logic [CSR_DATA_W-1:0] value);
      idle_requests(1);
      while (mask_words_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (sel == CSR_RADIUS_SQ) begin
         radius_q = value;
      end else begin
         count_q = value[COUNT_W-1:0];
      end
      settings_used++;
   endtask

   // Coordinates mostly in a small cluster so that hits are common.
   function automatic logic signed [COORD_W-1:0] make_coord();
      case ($urandom_range(0, 9)) inside
         0: return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
         1: return 16'sd0;
         [2:3]: return COORD_W'($urandom);
         default: return COORD_W'(int'($urandom_range(0, 255)) - 128);
      endcase
   endfunction

   function automatic frnn_req_type make_request(input logic cmd,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y);
      frnn_req_type item;
      item.command = cmd;
      item.point_index = idx;
      item.coord_0 = x;
      item.coord_1 = y;
      item.coord_2 = COORD_W'($urandom);
      item.coord_3 = COORD_W'($urandom);
      return item;
   endfunction

   // Response side: stall in random bursts unless idling is off.
   initial begin : rsp_pacing
      int run;
      rsp_ready = 1'b0;
      forever begin
         run = $urandom_range(1, 15);
         if (no_idle || $urandom_range(0, 3) != 0) begin
            repeat (run) begin
               @(negedge clock);
               rsp_ready <= 1'b1;
            end
         end else begin
            repeat (run) begin
               @(negedge clock);
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // Compare each accepted mask word with the oldest expected one.
   always @(posedge clock) begin : rsp_check
      frnn_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mask_words_q.size() == 0) begin
            note_mismatch($sformatf("unexpected word %0d mask %h last %b",
                                    rsp_payload.word_index, rsp_payload.neighbor_mask,
                                    rsp_payload.last_word));
         end else begin
            want = mask_words_q.pop_front();
            words_checked++;
            if (want.word_index != rsp_payload.word_index ||
                want.neighbor_mask != rsp_payload.neighbor_mask ||
                want.last_word != rsp_payload.last_word) begin
               note_mismatch($sformatf("expected word %0d mask %h last %b, got %0d %h %b",
                                       want.word_index, want.neighbor_mask, want.last_word,
                                       rsp_payload.word_index, rsp_payload.neighbor_mask,
                                       rsp_payload.last_word));
            end
         end
      end
   end

   // Main sequence: reset, directed rows, then random phases.
   initial begin : stimulus
      int                 eff;
      int                 fill;
      logic [INDEX_W-1:0] idx;
      row_type            row;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_idle = 1'b0;
      mismatch_count = 0;
      requests_sent = 0;
      queries_sent = 0;
      words_checked = 0;
      settings_used = 0;
      radius_q = RADIUS_SQ_RESET;
      count_q = POINT_COUNT_RESET;
      for (int i = 0; i < INDEX_LIMIT; i++) begin
         pt_written[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows.
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = DIR_TABLE[r];
         case (row.kind)
            ROW_REG: begin
               write_register(row.reg_sel, row.value);
            end
            ROW_LOAD: begin
               send_request(make_request(CMD_LOAD, row.index, row.cx, row.cy), 1'b0, '0);
            end
            default: begin
               send_request(make_request(CMD_QUERY, row.index, make_coord(), make_coord()),
                            row.fixed, row.mask);
            end
         endcase
      end

      // Random phases. Points below the count are loaded before any query
      // so that no query ever reads an unwritten entry.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_register(CSR_RADIUS_SQ, PHASE_TABLE[ph].radius);
         write_register(CSR_POINT_COUNT, CSR_DATA_W'(PHASE_TABLE[ph].count));
         no_idle = PHASE_TABLE[ph].quiet;
         eff = (count_q > COUNT_W'(INDEX_LIMIT)) ? INDEX_LIMIT : int'(count_q);
         for (int n = 0; n < int'(PHASE_TABLE[ph].items); n++) begin
            fill = -1;
            for (int p = eff - 1; p >= 0; p--) begin
               if (!pt_written[p]) begin
                  fill = p;
               end
            end
            if (fill >= 0) begin
               send_request(make_request(CMD_LOAD, INDEX_W'(fill), make_coord(), make_coord()),
                            1'b0, '0);
            end else if ($urandom_range(0, 99) < 60) begin
               idx = INDEX_W'($urandom_range(0, INDEX_LIMIT - 1));
               while (!pt_written[idx]) idx = INDEX_W'($urandom_range(0, INDEX_LIMIT - 1));
               send_request(make_request(CMD_QUERY, idx, make_coord(), make_coord()),
                            1'b0, '0);
            end else begin
               idx = INDEX_W'($urandom_range(0, INDEX_LIMIT - 1));
               send_request(make_request(CMD_LOAD, idx, make_coord(), make_coord()), 1'b0, '0);
            end
         end
      end

      // Drain the remaining mask words and let the core settle.
      idle_requests(1);
      while (mask_words_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d requests, %0d of them queries, over %0d register writes.",
               requests_sent, queries_sent, settings_used);
      $display("%0d mask words were checked; %0d mismatches were seen.",
               words_checked, mismatch_count);
      if (mismatch_count == 0 && mask_words_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
